[sv/i2cm_pkg.sv]
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared phase codes, constants and the sequencer, input and result structs for the I2C master.
// ----------------------------------------------------------------------------
package i2cm_pkg;
	localparam int PhW = 4;

	localparam logic [PhW-1:0] PH_IDLE      = 4'd0;
	localparam logic [PhW-1:0] PH_START_A   = 4'd1;
	localparam logic [PhW-1:0] PH_START_B   = 4'd2;
	localparam logic [PhW-1:0] PH_TX_SETUP  = 4'd3;
	localparam logic [PhW-1:0] PH_TX_HIGH   = 4'd4;
	localparam logic [PhW-1:0] PH_TX_LOW    = 4'd5;
	localparam logic [PhW-1:0] PH_ACK_LOW   = 4'd6;
	localparam logic [PhW-1:0] PH_ACK_HIGH  = 4'd7;
	localparam logic [PhW-1:0] PH_RX_LOW    = 4'd8;
	localparam logic [PhW-1:0] PH_RX_HIGH   = 4'd9;
	localparam logic [PhW-1:0] PH_MACK_LOW  = 4'd10;
	localparam logic [PhW-1:0] PH_MACK_HIGH = 4'd11;
	localparam logic [PhW-1:0] PH_STOP_A    = 4'd12;
	localparam logic [PhW-1:0] PH_STOP_B    = 4'd13;
	localparam logic [PhW-1:0] PH_ESTOP_A   = 4'd14;
	localparam logic [PhW-1:0] PH_ESTOP_B   = 4'd15;

	localparam logic [2:0] OP_WIDE_WR  = 3'd0;
	localparam logic [2:0] OP_WIDE_RD  = 3'd1;
	localparam logic [2:0] OP_BYTE_WR  = 3'd2;
	localparam logic [2:0] OP_BYTE_RD  = 3'd3;
	localparam logic [2:0] OP_MULTI_RD = 3'd4;

	localparam logic [7:0] TIMEOUT_RST = 8'd250;
	localparam logic [7:0] TOP_BIT     = 8'h80;

	// sequencer state
	typedef struct packed {
		logic [PhW-1:0] phase;
		logic [2:0]     dly;
		logic [2:0]     bitc;
		logic [7:0]     shift;
		logic [7:0]     poll;
		logic [7:0]     left;
		logic [2:0]     sent;
		logic [2:0]     op;
		logic [7:0]     dev;
		logic [15:0]    rg;
		logic [15:0]    val;
		logic [15:0]    wbuf;
		logic           scl;
		logic           sda;
	} seq_t;

	// one input word
	typedef struct packed {
		logic        kind;
		logic [2:0]  operation;
		logic [7:0]  device_address;
		logic [15:0] register_address;
		logic [15:0] write_value;
		logic [7:0]  read_length;
		logic        sda_sample;
	} in_word_t;

	// one result word
	typedef struct packed {
		logic        scl_level;
		logic        sda_drive_low;
		logic        busy_res;
		logic        byte_valid;
		logic [7:0]  read_byte;
		logic        last_byte;
		logic        done_res;
		logic        nack_error;
		logic [2:0]  failed_byte;
		logic [15:0] read_word;
	} out_word_t;
endpackage

[sv/i2cm_step.sv]
// ----------------------------------------------------------------------------
// i2cm_step
// Next-state and result logic for one word: one sequencer step.
// ----------------------------------------------------------------------------
module i2cm_step import i2cm_pkg::*; (
	input  seq_t      cur,
	input  in_word_t  w,
	input  logic [7:0] timeout,
	output seq_t      nxt,
	output out_word_t res
);
	function automatic logic [7:0] pick_byte(input seq_t s, input logic [2:0] idx);
		logic [7:0] rd;
		rd = s.dev + 8'd1;
		if (idx == 3'd0) return s.dev;
		if (s.op == OP_WIDE_WR) begin
			case (idx)
				3'd1: return s.rg[15:8];
				3'd2: return s.rg[7:0];
				3'd3: return s.val[15:8];
				default: return s.val[7:0];
			endcase
		end
		if (s.op == OP_WIDE_RD) begin
			if (idx == 3'd1) return s.rg[15:8];
			if (idx == 3'd2) return s.rg[7:0];
			return rd;
		end
		if (idx == 3'd1) return s.rg[7:0];
		return (s.op == OP_BYTE_WR) ? s.val[7:0] : rd;
	endfunction

	always_comb begin
		seq_t n;
		logic [2:0] ns;
		logic [2:0] lim;
		logic [7:0] sb;
		logic [7:0] nl;
		n = cur;
		res = '0;
		ns = cur.sent + 3'd1;
		lim = 3'd0;
		sb = '0;
		nl = cur.left - 8'd1;
		if (!w.kind) begin
			if (cur.phase == PH_IDLE && w.operation <= OP_MULTI_RD) begin
				n.op = w.operation;
				n.dev = w.device_address;
				n.rg = w.register_address;
				n.val = w.write_value;
				n.left = (w.operation == OP_WIDE_RD) ? 8'd2 :
					(w.operation == OP_BYTE_RD) ? 8'd1 : w.read_length;
				n.sent = '0; n.poll = '0; n.wbuf = '0;
				n.phase = PH_START_A; n.dly = 3'd4; n.scl = 1'b1; n.sda = 1'b0;
			end
		end else if (cur.phase != PH_IDLE) begin
			n.dly = cur.dly - 3'd1;
			if (n.dly == 3'd0) begin
				case (cur.phase)
					PH_START_A: begin
						n.phase = PH_START_B; n.dly = 3'd4; n.scl = 1'b1; n.sda = 1'b1;
					end
					PH_START_B: begin
						sb = pick_byte(cur, cur.sent);
						n.shift = sb; n.bitc = '0;
						n.phase = PH_TX_SETUP; n.dly = 3'd2; n.scl = 1'b0;
						n.sda = ~sb[7];
					end
					PH_TX_SETUP: begin
						n.phase = PH_TX_HIGH; n.dly = 3'd2; n.scl = 1'b1;
					end
					PH_TX_HIGH: begin
						n.phase = PH_TX_LOW; n.dly = 3'd2; n.scl = 1'b0;
					end
					PH_TX_LOW: begin
						if (cur.bitc == 3'd7) begin
							n.poll = '0;
							n.phase = PH_ACK_LOW; n.dly = 3'd1; n.scl = 1'b0; n.sda = 1'b0;
						end else begin
							n.bitc = cur.bitc + 3'd1;
							n.shift = {cur.shift[6:0], 1'b0};
							n.phase = PH_TX_SETUP; n.dly = 3'd2; n.scl = 1'b0;
							n.sda = ~cur.shift[6];
						end
					end
					PH_ACK_LOW: begin
						n.phase = PH_ACK_HIGH; n.dly = 3'd1; n.scl = 1'b1; n.sda = 1'b0;
					end
					PH_ACK_HIGH: begin
						if (!w.sda_sample) begin
							n.sent = ns;
							if (cur.op == OP_WIDE_WR || cur.op == OP_BYTE_WR) begin
								lim = (cur.op == OP_WIDE_WR) ? 3'd5 : 3'd3;
								if (ns < lim) begin
									sb = pick_byte(cur, ns);
									n.shift = sb; n.bitc = '0;
									n.phase = PH_TX_SETUP; n.dly = 3'd2; n.scl = 1'b0;
									n.sda = ~sb[7];
								end else begin
									n.phase = PH_STOP_A; n.dly = 3'd4; n.scl = 1'b0; n.sda = 1'b1;
								end
							end else begin
								lim = (cur.op == OP_WIDE_RD) ? 3'd3 : 3'd2;
								if (ns < lim) begin
									sb = pick_byte(cur, ns);
									n.shift = sb; n.bitc = '0;
									n.phase = PH_TX_SETUP; n.dly = 3'd2; n.scl = 1'b0;
									n.sda = ~sb[7];
								end else if (ns == lim) begin
									n.phase = PH_START_A; n.dly = 3'd4; n.scl = 1'b1; n.sda = 1'b0;
								end else if (cur.left == 8'd0) begin
									n.phase = PH_STOP_A; n.dly = 3'd4; n.scl = 1'b0; n.sda = 1'b1;
								end else begin
									n.shift = '0; n.bitc = '0;
									n.phase = PH_RX_LOW; n.dly = 3'd2; n.scl = 1'b0; n.sda = 1'b0;
								end
							end
						end else if (cur.poll >= timeout) begin
							n.phase = PH_ESTOP_A; n.dly = 3'd4; n.scl = 1'b0; n.sda = 1'b1;
						end else begin
							n.poll = cur.poll + 8'd1;
							n.phase = PH_ACK_HIGH; n.dly = 3'd1; n.scl = 1'b1; n.sda = 1'b0;
						end
					end
					PH_RX_LOW: begin
						n.phase = PH_RX_HIGH; n.dly = 3'd1; n.scl = 1'b1; n.sda = 1'b0;
					end
					PH_RX_HIGH: begin
						sb = {cur.shift[6:0], w.sda_sample};
						n.shift = sb;
						if (cur.bitc == 3'd7) begin
							res.byte_valid = 1'b1;
							res.read_byte = sb;
							res.last_byte = (cur.left == 8'd1);
							if (cur.op == OP_WIDE_RD) n.wbuf = {cur.wbuf[7:0], sb};
							n.phase = PH_MACK_LOW; n.dly = 3'd2; n.scl = 1'b0;
							n.sda = (cur.left > 8'd1);
						end else begin
							n.bitc = cur.bitc + 3'd1;
							n.phase = PH_RX_LOW; n.dly = 3'd2; n.scl = 1'b0; n.sda = 1'b0;
						end
					end
					PH_MACK_LOW: begin
						n.phase = PH_MACK_HIGH; n.dly = 3'd2; n.scl = 1'b1;
					end
					PH_MACK_HIGH: begin
						n.left = nl;
						if (nl == 8'd0) begin
							n.phase = PH_STOP_A; n.dly = 3'd4; n.scl = 1'b0; n.sda = 1'b1;
						end else begin
							n.shift = '0; n.bitc = '0;
							n.phase = PH_RX_LOW; n.dly = 3'd2; n.scl = 1'b0; n.sda = 1'b0;
						end
					end
					PH_STOP_A: begin
						n.phase = PH_STOP_B; n.dly = 3'd4; n.scl = 1'b1; n.sda = 1'b1;
					end
					PH_ESTOP_A: begin
						n.phase = PH_ESTOP_B; n.dly = 3'd4; n.scl = 1'b1; n.sda = 1'b1;
					end
					PH_STOP_B: begin
						n.phase = PH_IDLE; n.dly = '0; n.scl = 1'b1; n.sda = 1'b0;
						res.done_res = 1'b1;
						if (cur.op == OP_WIDE_RD) res.read_word = cur.wbuf;
					end
					PH_ESTOP_B: begin
						n.phase = PH_IDLE; n.dly = '0; n.scl = 1'b1; n.sda = 1'b0;
						res.done_res = 1'b1; res.nack_error = 1'b1;
						res.failed_byte = cur.sent;
					end
					default: begin
						n.phase = PH_IDLE; n.dly = '0; n.scl = 1'b1; n.sda = 1'b0;
					end
				endcase
			end
		end
		nxt = n;
		res.scl_level = n.scl;
		res.sda_drive_low = n.sda;
		res.busy_res = (n.phase != PH_IDLE);
	end
endmodule

[sv/i2c_master_register_access.sv]
// ----------------------------------------------------------------------------
// i2c_master_register_access
// Open-drain I2C master running register read/write transactions, one tick word
// per microsecond.
// ----------------------------------------------------------------------------
// Each accepted word's result is registered, in the skid register while the output waits.
// Throughput: one word per cycle while the skid is empty; the result register is backed
//   by a skid register so input is taken while one result waits for the consumer.
// Reset: arst_n clears the sequencer to idle with SCL high and SDA released,
//   and loads the acknowledge timeout with 250.
module i2c_master_register_access import i2cm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: acknowledge timeout
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [2:0]  operation,
	input  logic [7:0]  device_address,
	input  logic [15:0] register_address,
	input  logic [15:0] write_value,
	input  logic [7:0]  read_length,
	input  logic        sda_sample,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        scl_level,
	output logic        sda_drive_low,
	output logic        busy_res,
	output logic        byte_valid,
	output logic [7:0]  read_byte,
	output logic        last_byte,
	output logic        done_res,
	output logic        nack_error,
	output logic [2:0]  failed_byte,
	output logic [15:0] read_word
);
	// idle sequencer, SCL high, everything else clear
	localparam seq_t SEQ_RST = '{scl: 1'b1, default: '0};

	seq_t      seq_q, seq_nxt;
	in_word_t  win;
	out_word_t res, out_q, skid_q;
	logic [7:0] timeout_q;
	logic       out_vld_q, skid_vld_q, acc;

	assign win = '{kind, operation, device_address, register_address,
		write_value, read_length, sda_sample};

	// stall only when the skid holds a word
	assign in_stall = skid_vld_q;
	assign acc = in_valid && !in_stall;

	i2cm_step u_step (
		.cur    (seq_q),
		.w      (win),
		.timeout(timeout_q),
		.nxt    (seq_nxt),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
			seq_q <= SEQ_RST;
			out_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (cfg_we) timeout_q <= cfg_wdata;
			if (acc) seq_q <= seq_nxt;
			// output register / skid handling
			if (!out_vld_q || !out_stall) begin
				out_vld_q <= skid_vld_q || acc;
				skid_vld_q <= 1'b0;
			end else if (acc) begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || !out_stall) begin
			out_q <= skid_vld_q ? skid_q : res;
		end else if (acc) begin
			skid_q <= res;
		end
	end

	assign out_valid     = out_vld_q;
	assign scl_level     = out_q.scl_level;
	assign sda_drive_low = out_q.sda_drive_low;
	assign busy_res      = out_q.busy_res;
	assign byte_valid    = out_q.byte_valid;
	assign read_byte     = out_q.read_byte;
	assign last_byte     = out_q.last_byte;
	assign done_res      = out_q.done_res;
	assign nack_error    = out_q.nack_error;
	assign failed_byte   = out_q.failed_byte;
	assign read_word     = out_q.read_word;
endmodule

[sv/i2cm_checker.sv]
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks on the I2C master result stream.
// ----------------------------------------------------------------------------
module i2cm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       busy_res,
	input logic       done_res,
	input logic       nack_error,
	input logic       byte_valid,
	input logic [7:0] read_byte
);
	// an error always comes with done
	a_err_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && nack_error |-> done_res)
		else $error("nack without done");
	// done means the block went idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res)
		else $error("done while busy");
	// no byte delivered together with done
	a_byte_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_valid |-> !done_res)
		else $error("byte on done word");
	// a stalled word stays valid and keeps its read byte
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_byte))
		else $error("stalled word changed");
endmodule

bind i2c_master_register_access i2cm_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_stall(out_stall),
	.busy_res(busy_res), .done_res(done_res), .nack_error(nack_error),
	.byte_valid(byte_valid), .read_byte(read_byte)
);
